>>> hdl/tga2pl_pkg.sv
// Shared types, constants and codes for the TGA to planar RGB converter.
package tga2pl_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = $clog2(MAX_WIDTH + 1);
  localparam int PIX_W     = 24;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BUSY     = 3'd1;
  localparam logic [2:0] STAT_BAD_TYPE = 3'd2;
  localparam logic [2:0] STAT_BAD_SIZE = 3'd3;
  localparam logic [2:0] STAT_WIDE     = 3'd4;
  localparam logic [2:0] STAT_DONE     = 3'd5;

  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;
  localparam logic [4:0] HDR_LEN       = 5'd18;

  localparam logic [7:0] TGA_TYPE_RGB = 8'd2;
  localparam logic [7:0] BPP_16       = 8'd16;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] BPP_32       = 8'd32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [1:0] {
    PM_16 = 2'd0,
    PM_24 = 2'd1,
    PM_32 = 2'd2
  } pix_mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } fsm_state_t;

endpackage

>>> hdl/tga2pl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tga2pl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tga2pl_unpack.sv
// Pixel unpacker that turns gathered TGA pixel bytes into an R:G:B word.
module tga2pl_unpack (
  input  tga2pl_pkg::pix_mode_t          pixel_mode,
  input  logic [tga2pl_pkg::PIX_W-1:0]   pixel_bytes,
  output logic [tga2pl_pkg::PIX_W-1:0]   rgb
);

  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;

  always_comb begin
    lo = pixel_bytes[7:0];
    hi = pixel_bytes[15:8];
    if (pixel_mode == tga2pl_pkg::PM_16) begin
      r = {hi[6:2], 3'b000};
      g = {hi[1:0], lo[7:5], 3'b000};
      b = {lo[4:0], 3'b000};
    end else begin
      r = pixel_bytes[23:16];
      g = pixel_bytes[15:8];
      b = pixel_bytes[7:0];
    end
    rgb = {r, g, b};
  end

endmodule

>>> hdl/tga_to_planar_rgb_converter.sv
// Top level of the TGA to planar RGB converter: control, state and line store.
//
// Usage: raise start with operation and data_byte while busy is low. Operation
// OP_PUSH feeds one TGA file byte; OP_PULL asks for one output byte. The beat
// is taken at the clock edge where start is high and busy is low.
// Each command gives exactly one result, shown for one cycle with done high:
// out_valid, out_byte, status and line_end. The receiver cannot stall; the
// result must be captured in that cycle.
// The command is registered when taken and executed while busy is high;
// the result is registered at the end of execution, so a new command can be
// given in the same cycle that shows the previous result. The busy state is
// set by the line store read: the read of the drain position is registered in
// the RAM, and the command is executed in the cycle after.
// Decoded pixels are written into a line store RAM of MAX_WIDTH entries, and
// pulls read the red, green and blue planes back from it.
// Reset (rst, synchronous) clears all control state, the header count and
// the error code; the line store is not cleared, since every entry is written
// for a line before it is drained.
module tga_to_planar_rgb_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [7:0] data_byte,
  output logic       done,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       line_end
);

  localparam int AW = tga2pl_pkg::ADDR_W;
  localparam int CW = tga2pl_pkg::COL_W;
  localparam int PW = tga2pl_pkg::PIX_W;

  tga2pl_pkg::fsm_state_t state, state_next;
  logic accept;
  logic exec;

  logic       op_q;
  logic [7:0] byte_q;

  logic [4:0]            header_count, header_count_next;
  logic [15:0]           image_width, image_width_next;
  logic [15:0]           image_height, image_height_next;
  tga2pl_pkg::pix_mode_t pixel_mode, pixel_mode_next;
  logic [15:0]           line_number, line_number_next;
  logic [1:0]            byte_in_pixel, byte_in_pixel_next;
  logic [CW-1:0]         column, column_next;
  logic [PW-1:0]         pixel_bytes, pixel_bytes_next;
  logic                  drain_active, drain_active_next;
  logic [1:0]            drain_plane, drain_plane_next;
  logic [CW-1:0]         drain_position, drain_position_next;
  logic [2:0]            error_code, error_code_next;

  logic          res_valid;
  logic [7:0]    res_byte;
  logic [2:0]    res_status;
  logic          res_end;

  logic          ram_we;
  logic [PW-1:0] ram_rdata;
  logic [PW-1:0] gathered;
  logic [PW-1:0] rgb;

  tga2pl_unpack u_unpack (
    .pixel_mode  (pixel_mode),
    .pixel_bytes (gathered),
    .rgb         (rgb)
  );

  tga2pl_ram #(
    .WIDTH (PW),
    .DEPTH (tga2pl_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (column[AW-1:0]),
    .wdata (rgb),
    .raddr (drain_position[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (state)
      tga2pl_pkg::ST_IDLE: state_next = start ? tga2pl_pkg::ST_EXEC : tga2pl_pkg::ST_IDLE;
      tga2pl_pkg::ST_EXEC: state_next = tga2pl_pkg::ST_IDLE;
      default:             state_next = tga2pl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state == tga2pl_pkg::ST_EXEC);
    exec = (state == tga2pl_pkg::ST_EXEC);
  end

  assign accept = start && !busy;

  always_comb begin
    logic [15:0]   w;
    logic [CW-1:0] col1;
    logic [CW-1:0] pos1;
    logic [15:0]   last;
    logic [2:0]    plane1;
    logic [15:0]   ln1;
    logic [PW-1:0] px;

    header_count_next   = header_count;
    image_width_next    = image_width;
    image_height_next   = image_height;
    pixel_mode_next     = pixel_mode;
    line_number_next    = line_number;
    byte_in_pixel_next  = byte_in_pixel;
    column_next         = column;
    pixel_bytes_next    = pixel_bytes;
    drain_active_next   = drain_active;
    drain_plane_next    = drain_plane;
    drain_position_next = drain_position;
    error_code_next     = error_code;
    res_valid           = 1'b0;
    res_byte            = 8'd0;
    res_end             = 1'b0;
    ram_we              = 1'b0;
    gathered            = pixel_bytes;
    w                   = image_width;
    col1                = column + CW'(1);
    pos1                = drain_position + CW'(1);
    last                = 16'd2;
    plane1              = {1'b0, drain_plane} + 3'd1;
    ln1                 = line_number + 16'd1;
    px                  = '0;

    unique case (byte_in_pixel)
      2'd0:    gathered = pixel_bytes | {16'd0, byte_q};
      2'd1:    gathered = pixel_bytes | {8'd0, byte_q, 8'd0};
      2'd2:    gathered = pixel_bytes | {byte_q, 16'd0};
      default: gathered = pixel_bytes;
    endcase

    if (error_code != tga2pl_pkg::STAT_OK) begin
      res_status = error_code;
    end else if (op_q == tga2pl_pkg::OP_PUSH && drain_active) begin
      res_status = tga2pl_pkg::STAT_BUSY;
    end else begin
      if (op_q == tga2pl_pkg::OP_PUSH && header_count < tga2pl_pkg::HDR_LEN) begin
        header_count_next = header_count + 5'd1;
        priority case (header_count)
          tga2pl_pkg::HDR_TYPE: begin
            if (byte_q != tga2pl_pkg::TGA_TYPE_RGB) begin
              error_code_next = tga2pl_pkg::STAT_BAD_TYPE;
            end
          end
          tga2pl_pkg::HDR_WIDTH_LO: begin
            image_width_next = {8'd0, byte_q};
            res_valid = 1'b1;
            res_byte = byte_q;
          end
          tga2pl_pkg::HDR_WIDTH_HI: begin
            w = {byte_q, image_width[7:0]};
            image_width_next = w;
            if (w > 16'(tga2pl_pkg::MAX_WIDTH)) begin
              error_code_next = tga2pl_pkg::STAT_WIDE;
            end else begin
              res_valid = 1'b1;
              res_byte = byte_q;
            end
          end
          tga2pl_pkg::HDR_HEIGHT_LO: begin
            image_height_next = {8'd0, byte_q};
            res_valid = 1'b1;
            res_byte = byte_q;
          end
          tga2pl_pkg::HDR_HEIGHT_HI: begin
            image_height_next = {byte_q, image_height[7:0]};
            res_valid = 1'b1;
            res_byte = byte_q;
          end
          tga2pl_pkg::HDR_DEPTH: begin
            if (byte_q == tga2pl_pkg::BPP_16) begin
              pixel_mode_next = tga2pl_pkg::PM_16;
            end else if (byte_q == tga2pl_pkg::BPP_24) begin
              pixel_mode_next = tga2pl_pkg::PM_24;
            end else if (byte_q == tga2pl_pkg::BPP_32) begin
              pixel_mode_next = tga2pl_pkg::PM_32;
            end else begin
              error_code_next = tga2pl_pkg::STAT_BAD_SIZE;
            end
          end
          tga2pl_pkg::HDR_LAST: begin
            if (line_number >= image_height) begin
              error_code_next = tga2pl_pkg::STAT_DONE;
            end else if (image_width == 16'd0) begin
              drain_active_next = 1'b1;
              drain_plane_next = 2'd0;
              drain_position_next = '0;
            end
          end
          default: begin
          end
        endcase
      end else if (op_q == tga2pl_pkg::OP_PUSH) begin
        if (byte_in_pixel != 2'(pixel_mode) + 2'd1) begin
          byte_in_pixel_next = byte_in_pixel + 2'd1;
          pixel_bytes_next = gathered;
        end else begin
          ram_we = exec && (column < CW'(tga2pl_pkg::MAX_WIDTH));
          byte_in_pixel_next = 2'd0;
          pixel_bytes_next = '0;
          if (16'(col1) >= image_width) begin
            column_next = '0;
            drain_active_next = 1'b1;
            drain_plane_next = 2'd0;
            drain_position_next = '0;
          end else begin
            column_next = col1;
          end
        end
      end else if (drain_active) begin
        if (drain_plane == 2'd0) begin
          res_byte = (drain_position == '0) ? line_number[7:0] : line_number[15:8];
          last = 16'd2;
        end else begin
          px = (drain_position < CW'(tga2pl_pkg::MAX_WIDTH)) ? ram_rdata : '0;
          unique case (drain_plane)
            2'd1:    res_byte = px[23:16];
            2'd2:    res_byte = px[15:8];
            default: res_byte = px[7:0];
          endcase
          last = image_width;
        end
        res_valid = 1'b1;
        drain_position_next = pos1;
        if (16'(pos1) >= last) begin
          drain_position_next = '0;
          if (image_width == 16'd0 || plane1 > 3'd3) begin
            res_end = 1'b1;
            drain_active_next = 1'b0;
            drain_plane_next = 2'd0;
            line_number_next = ln1;
            if (ln1 >= image_height) begin
              error_code_next = tga2pl_pkg::STAT_DONE;
            end else if (image_width == 16'd0) begin
              drain_active_next = 1'b1;
            end
          end else begin
            drain_plane_next = plane1[1:0];
          end
        end
      end
      res_status = error_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tga2pl_pkg::ST_IDLE;
      done           <= 1'b0;
      header_count   <= '0;
      image_width    <= '0;
      image_height   <= '0;
      pixel_mode     <= tga2pl_pkg::PM_16;
      line_number    <= '0;
      byte_in_pixel  <= '0;
      column         <= '0;
      pixel_bytes    <= '0;
      drain_active   <= 1'b0;
      drain_plane    <= '0;
      drain_position <= '0;
      error_code     <= tga2pl_pkg::STAT_OK;
    end else begin
      state <= state_next;
      done  <= exec;
      if (exec) begin
        header_count   <= header_count_next;
        image_width    <= image_width_next;
        image_height   <= image_height_next;
        pixel_mode     <= pixel_mode_next;
        line_number    <= line_number_next;
        byte_in_pixel  <= byte_in_pixel_next;
        column         <= column_next;
        pixel_bytes    <= pixel_bytes_next;
        drain_active   <= drain_active_next;
        drain_plane    <= drain_plane_next;
        drain_position <= drain_position_next;
        error_code     <= error_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      byte_q <= data_byte;
    end
    if (exec) begin
      out_valid <= res_valid;
      out_byte  <= res_byte;
      status    <= res_status;
      line_end  <= res_end;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an executed beat");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("line store written outside execution");

  a_end_has_byte: assert property (@(posedge clk) disable iff (rst)
    done && line_end |-> out_valid)
    else $error("line end marked on a result without a byte");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= tga2pl_pkg::STAT_DONE)
    else $error("status code out of range");

endmodule
